// ===== design/mkdr_pkg.sv =====
// ----------------------------------------------------------------------------
// mkdr_pkg: shared types and constants of the key debounce reporter
// Register indexes, field widths, queue sizing and the front/back entry type.
// ----------------------------------------------------------------------------
package mkdr_pkg;

  localparam int NumButtonsDef = 8;
  localparam int CountWidthDef = 16;
  localparam int BtnMax        = 8;
  localparam int IdxW          = 3;
  localparam int CodeW         = 16;
  localparam int DebounceW     = 16;
  localparam int InW           = 8;
  localparam int OutW          = 24;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 64;
  localparam int QueueDepth    = 4;

  localparam logic [DebounceW-1:0] ResetDebounce = 16'd10;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDebounce = 3'd0;
  localparam logic [CfgIdxW-1:0] RegReportEn = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRestart  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegActive   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCodesLo  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCodesHi  = 3'd5;

  // one queue entry: buttons to report for a tick and their pressed flags
  typedef struct packed {
    logic [BtnMax-1:0] report;
    logic [BtnMax-1:0] pressed;
  } evt_t;

  // settings the front needs
  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic                 report_en;
    logic                 restart;
    logic [BtnMax-1:0]    active_mask;
  } front_cfg_t;

endpackage

// ===== design/mkdr_front.sv =====
// ----------------------------------------------------------------------------
// mkdr_front: per-tick countdown lanes
// Takes one tick, updates every button lane at once, and hands the set of
// buttons to report to the queue.
// ----------------------------------------------------------------------------
module mkdr_front #(
  parameter int NUM_BUTTONS = mkdr_pkg::NumButtonsDef,
  parameter int COUNT_WIDTH = mkdr_pkg::CountWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mkdr_pkg::front_cfg_t      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mkdr_pkg::InW-1:0]  pins_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output mkdr_pkg::evt_t            evt_o
);

  localparam logic [32:0] CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;

  logic [NUM_BUTTONS-1:0] prev_q, prev_d;
  logic [NUM_BUTTONS-1:0] rep_q, rep_d;
  logic [NUM_BUTTONS-1:0] armed_q, armed_d;
  logic [COUNT_WIDTH-1:0] cnt_q [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] cnt_d [NUM_BUTTONS];
  logic [COUNT_WIDTH-1:0] dec   [NUM_BUTTONS];

  logic [NUM_BUTTONS-1:0] pins, edges, armed_mid, report, pressed;
  logic [COUNT_WIDTH-1:0] load;
  logic [32:0]            ticks_ext;
  logic                   accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // reload value: zero counts as one, saturate to the counter width
  always_comb begin
    ticks_ext = 33'(cfg_i.debounce_ticks);
    if (ticks_ext == 33'd0) begin
      load = COUNT_WIDTH'(1);
    end else if (ticks_ext > CountMax) begin
      load = '1;
    end else begin
      load = COUNT_WIDTH'(ticks_ext);
    end
  end

  always_comb begin
    pins    = pins_i[NUM_BUTTONS-1:0];
    edges   = pins ^ prev_q;
    prev_d  = pins;
    rep_d   = rep_q;
    report  = '0;
    pressed = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      armed_mid[i] = armed_q[i];
      dec[i]       = (cnt_q[i] != '0) ? cnt_q[i] - COUNT_WIDTH'(1) : cnt_q[i];
      cnt_d[i]     = cnt_q[i];
      // expiry first, judged with this tick's level
      if (armed_q[i]) begin
        cnt_d[i] = dec[i];
        if (dec[i] == '0) begin
          armed_mid[i] = 1'b0;
          if (pins[i] != rep_q[i]) begin
            rep_d[i]   = pins[i];
            report[i]  = cfg_i.report_en;
            pressed[i] = (pins[i] == cfg_i.active_mask[i]);
          end
        end
      end
      // then edges arm, or rearm when restart is on
      armed_d[i] = armed_mid[i];
      if (edges[i] && (!armed_mid[i] || cfg_i.restart)) begin
        armed_d[i] = 1'b1;
        cnt_d[i]   = load;
      end
    end
  end

  assign evt_o.report  = mkdr_pkg::BtnMax'(report);
  assign evt_o.pressed = mkdr_pkg::BtnMax'(pressed);
  assign push_o        = accept && (|report);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      rep_q   <= '0;
      armed_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (accept) begin
      prev_q  <= prev_d;
      rep_q   <= rep_d;
      armed_q <= armed_d;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

// ===== design/mkdr_queue.sv =====
// ----------------------------------------------------------------------------
// mkdr_queue: short queue between front and back
// Holds report sets of ticks whose events are not yet sent.
// ----------------------------------------------------------------------------
module mkdr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mkdr_pkg::evt_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output mkdr_pkg::evt_t data_o
);

  localparam int Depth = mkdr_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  mkdr_pkg::evt_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("queue pop while empty");
  a_push_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (data_i.report != '0)) else $error("empty report set queued");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

// ===== design/mkdr_back.sv =====
// ----------------------------------------------------------------------------
// mkdr_back: event serializer
// Walks a report set from the lowest button up, one event per cycle while
// the receiver is ready, into the output register.
// ----------------------------------------------------------------------------
module mkdr_back (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [mkdr_pkg::BtnMax*mkdr_pkg::CodeW-1:0] codes_i,
  input  logic                                    q_valid_i,
  input  mkdr_pkg::evt_t                          q_data_i,
  output logic                                    pop_o,
  output logic                                    m_tvalid_o,
  input  logic                                    m_tready_i,
  output logic [mkdr_pkg::OutW-1:0]               m_tdata_o,
  output logic                                    m_tlast_o
);

  localparam int BtnMax = mkdr_pkg::BtnMax;
  localparam int IdxW   = mkdr_pkg::IdxW;
  localparam int CodeW  = mkdr_pkg::CodeW;
  localparam int OutW   = mkdr_pkg::OutW;

  logic [BtnMax-1:0] work_q, work_d, prs_q, remaining;
  logic [IdxW-1:0]   idx;
  logic [CodeW-1:0]  code;
  logic              adv, emit, work_busy;

  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_data_q, out_data_d;
  logic              out_last_q, out_last_d;

  always_comb begin
    idx = '0;
    for (int i = BtnMax - 1; i >= 0; i--) begin
      if (work_q[i]) begin
        idx = IdxW'(i);
      end
    end
  end

  assign code      = codes_i[idx*CodeW +: CodeW];
  assign remaining = work_q & (work_q - BtnMax'(1));
  assign work_busy = |work_q;
  assign adv       = !out_valid_q || m_tready_i;
  assign emit      = adv && work_busy;
  assign pop_o     = q_valid_i && (!work_busy || (emit && (remaining == '0)));

  always_comb begin
    work_d      = work_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    if (emit) begin
      work_d      = remaining;
      out_valid_d = 1'b1;
      out_data_d  = OutW'({idx, prs_q[idx], code});
      out_last_d  = (remaining == '0);
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      work_d = q_data_i.report;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q      <= work_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    if (pop_o) begin
      prs_q <= q_data_i.pressed;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;

endmodule

// ===== design/multi_key_debounce_reporter.sv =====
// ----------------------------------------------------------------------------
// multi_key_debounce_reporter: debouncer and key event reporter
// Tick-driven countdown per button; reports debounced level changes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per timer tick; tdata[7:0] holds the sampled pin
//   levels, bit i for button i. Each tick updates all button countdowns in
//   the cycle it is accepted; a button whose countdown runs out with a level
//   that differs from the last judged one yields one event if reporting is enabled.
//   m_axis carries events in rising button order: key code, pressed flag and
//   button index in tdata, tlast set on the last event of a tick. A tick
//   with nothing to report gives no item.
//   cfg writes registers by index (0 debounce ticks, 1 reporting enable,
//   2 restart on edge, 3 active level mask, 4/5 key codes); write only when
//   the block is idle. cfg_ready_o is always high.
// Timing:
//   The first event of a tick passes through the queue, the set register and
//   the output register. Events stream at one per cycle while the receiver
//   is ready; ticks are taken one per cycle while the four-entry event
//   queue has room.
// Reset: all levels, countdowns and configuration registers clear, debounce ticks is 10.
// Stall: a stalled receiver holds the output register; the queue fills
//   and then s_axis_tready drops until an entry drains.
// ----------------------------------------------------------------------------
module multi_key_debounce_reporter #(
  parameter int NUM_BUTTONS = mkdr_pkg::NumButtonsDef,
  parameter int COUNT_WIDTH = mkdr_pkg::CountWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tick input
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mkdr_pkg::InW-1:0]        s_axis_tdata,   // [7:0] pin_levels
  // event output
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] key_code, [16] pressed, [19:17] button_index, [23:20] zero
  output logic [mkdr_pkg::OutW-1:0]       m_axis_tdata,
  output logic                            m_axis_tlast,   // last_event
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mkdr_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mkdr_pkg::CfgDataW-1:0]   cfg_data_i
);

  // configuration registers
  logic [mkdr_pkg::DebounceW-1:0] debounce_q;
  logic                           report_en_q;
  logic                           restart_q;
  logic [mkdr_pkg::BtnMax-1:0]    active_q;
  logic [mkdr_pkg::CfgDataW-1:0]  codes_lo_q;
  logic [mkdr_pkg::CfgDataW-1:0]  codes_hi_q;

  mkdr_pkg::front_cfg_t front_cfg;
  mkdr_pkg::evt_t       push_evt, pop_evt;
  logic                 push, pop, q_full, q_valid;
  logic                 cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= mkdr_pkg::ResetDebounce;
      report_en_q <= 1'b0;
      restart_q   <= 1'b0;
      active_q    <= '0;
      codes_lo_q  <= '0;
      codes_hi_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        mkdr_pkg::RegDebounce: debounce_q  <= cfg_data_i[mkdr_pkg::DebounceW-1:0];
        mkdr_pkg::RegReportEn: report_en_q <= cfg_data_i[0];
        mkdr_pkg::RegRestart:  restart_q   <= cfg_data_i[0];
        mkdr_pkg::RegActive:   active_q    <= cfg_data_i[mkdr_pkg::BtnMax-1:0];
        mkdr_pkg::RegCodesLo:  codes_lo_q  <= cfg_data_i;
        mkdr_pkg::RegCodesHi:  codes_hi_q  <= cfg_data_i;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign front_cfg.debounce_ticks = debounce_q;
  assign front_cfg.report_en      = report_en_q;
  assign front_cfg.restart        = restart_q;
  assign front_cfg.active_mask    = active_q;

  mkdr_front #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (front_cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .pins_i     (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .evt_o      (push_evt)
  );

  mkdr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_evt),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (pop_evt)
  );

  mkdr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .codes_i    ({codes_hi_q, codes_lo_q}),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_evt),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
